// ===== sv/ssi_pkg.sv =====
package ssi_pkg;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_PRESENT  = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_COMPARE,
    S_SHIFT,
    S_INSERT
  } state_t;

endpackage

// ===== sv/ssi_ram.sv =====
module ssi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/sorted_set_insert.sv =====
// channel   direction  transfer when    payload
// command   in         start && !busy   key
// result    out        done             status, position, count
//
// an item takes a memory read, then a compare, for each binary search step;
// if the key is not found and the table is not full, it then moves the
// entries from the insert point down one place each, one at a time, and
// then writes the key; the single memory port pair sets the shift rate
// synchronous reset empties the table at once, the memory is not cleared
// the result is shown for one cycle only: the receiver cannot stall
module sorted_set_insert #(
  parameter int CAPACITY  = 256,
  parameter int KEY_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] key,
  output logic        busy,
  output logic        done,
  output logic [1:0]  status,
  output logic [7:0]  position,
  output logic [8:0]  count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = (KEY_BYTES >= 4) ? 32 : 8 * KEY_BYTES;

  ssi_pkg::state_t state, state_next;

  logic [KW-1:0] kreg, kreg_next;
  logic [CW-1:0] lo, lo_next;
  logic [CW-1:0] hi, hi_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] mid, mid_next;
  logic [CW-1:0] j, j_next;
  logic [AW-1:0] wr_addr, wr_addr_next;
  logic          pend, pend_next;

  logic            done_next;
  ssi_pkg::status_t status_r, status_next;
  logic [7:0]      position_r, position_next;
  logic [8:0]      count_r, count_next;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [KW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [KW-1:0] ram_rdata;

  logic [CW:0]   sum;
  logic [CW-1:0] mid_calc;
  logic [CW-1:0] j_dec;
  logic [CW-1:0] cnt_inc;
  logic [31:0]   lo_wide, mid_wide, cnt_wide, cnt_inc_wide;

  ssi_ram #(
    .WIDTH (KW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign sum          = {1'b0, lo} + {1'b0, hi};
  assign mid_calc     = sum[CW:1];
  assign j_dec        = j - 1'b1;
  assign cnt_inc      = cnt + 1'b1;
  assign lo_wide      = 32'(lo);
  assign mid_wide     = 32'(mid);
  assign cnt_wide     = 32'(cnt);
  assign cnt_inc_wide = 32'(cnt_inc);

  always_comb begin
    state_next = state;
    case (state)
      ssi_pkg::S_IDLE: begin
        if (start) state_next = ssi_pkg::S_SEARCH;
      end
      ssi_pkg::S_SEARCH: begin
        if (hi > lo) begin
          state_next = ssi_pkg::S_COMPARE;
        end else if (cnt == CW'(CAPACITY)) begin
          state_next = ssi_pkg::S_IDLE;
        end else begin
          state_next = ssi_pkg::S_SHIFT;
        end
      end
      ssi_pkg::S_COMPARE: begin
        if (ram_rdata == kreg) state_next = ssi_pkg::S_IDLE;
        else state_next = ssi_pkg::S_SEARCH;
      end
      ssi_pkg::S_SHIFT: begin
        if (j <= lo) state_next = ssi_pkg::S_INSERT;
      end
      ssi_pkg::S_INSERT: begin
        state_next = ssi_pkg::S_IDLE;
      end
      default: state_next = ssi_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    kreg_next     = kreg;
    lo_next       = lo;
    hi_next       = hi;
    cnt_next      = cnt;
    mid_next      = mid;
    j_next        = j;
    wr_addr_next  = wr_addr;
    pend_next     = pend;
    done_next     = 1'b0;
    status_next   = status_r;
    position_next = position_r;
    count_next    = count_r;
    ram_we        = 1'b0;
    ram_waddr     = wr_addr;
    ram_wdata     = ram_rdata;
    ram_raddr     = mid_calc[AW-1:0];
    case (state)
      ssi_pkg::S_IDLE: begin
        if (start) begin
          kreg_next = key[KW-1:0];
          lo_next   = '0;
          hi_next   = cnt;
        end
      end
      ssi_pkg::S_SEARCH: begin
        if (hi > lo) begin
          mid_next = mid_calc;
        end else if (cnt == CW'(CAPACITY)) begin
          done_next     = 1'b1;
          status_next   = ssi_pkg::ST_FULL;
          position_next = '0;
          count_next    = cnt_wide[8:0];
        end else begin
          j_next    = cnt;
          pend_next = 1'b0;
        end
      end
      ssi_pkg::S_COMPARE: begin
        if (ram_rdata == kreg) begin
          done_next     = 1'b1;
          status_next   = ssi_pkg::ST_PRESENT;
          position_next = mid_wide[7:0];
          count_next    = cnt_wide[8:0];
        end else if (ram_rdata < kreg) begin
          hi_next = mid;
        end else begin
          lo_next = mid + 1'b1;
        end
      end
      ssi_pkg::S_SHIFT: begin
        ram_we    = pend;
        ram_raddr = j_dec[AW-1:0];
        if (j > lo) begin
          wr_addr_next = j[AW-1:0];
          j_next       = j_dec;
          pend_next    = 1'b1;
        end else begin
          pend_next = 1'b0;
        end
      end
      ssi_pkg::S_INSERT: begin
        ram_we        = 1'b1;
        ram_waddr     = lo[AW-1:0];
        ram_wdata     = kreg;
        cnt_next      = cnt_inc;
        done_next     = 1'b1;
        status_next   = ssi_pkg::ST_INSERTED;
        position_next = lo_wide[7:0];
        count_next    = cnt_inc_wide[8:0];
      end
      default: begin
        pend_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssi_pkg::S_IDLE;
      cnt   <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      pend  <= pend_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    kreg       <= kreg_next;
    lo         <= lo_next;
    hi         <= hi_next;
    mid        <= mid_next;
    j          <= j_next;
    wr_addr    <= wr_addr_next;
    status_r   <= status_next;
    position_r <= position_next;
    count_r    <= count_next;
  end

  assign busy     = (state != ssi_pkg::S_IDLE);
  assign status   = status_r;
  assign position = position_r;
  assign count    = count_r;

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == ssi_pkg::S_IDLE))
    else $error("result strobe outside idle");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("stored count above capacity");

  a_count_match: assert property (@(posedge clk) disable iff (rst)
    done |-> (count_r == cnt_wide[8:0]))
    else $error("reported count differs from stored count");

  a_search_window: assert property (@(posedge clk) disable iff (rst)
    (state == ssi_pkg::S_COMPARE) |-> (lo < hi && mid >= lo && mid < hi))
    else $error("probe outside search window");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not start work");

endmodule
